/* sv/stt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes of the software timer table
// Request and result items, request and status codes, and the cell records.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam logic [3:0] REQ_START_EV    = 4'd0;
	localparam logic [3:0] REQ_START_RL_EV = 4'd1;
	localparam logic [3:0] REQ_START_CB    = 4'd2;
	localparam logic [3:0] REQ_START_RL_CB = 4'd3;
	localparam logic [3:0] REQ_STOP_EV     = 4'd4;
	localparam logic [3:0] REQ_STOP_CB     = 4'd5;
	localparam logic [3:0] REQ_READ        = 4'd6;
	localparam logic [3:0] REQ_TICK        = 4'd7;
	localparam logic [3:0] REQ_COUNT       = 4'd8;
	localparam logic [3:0] REQ_NEXT        = 4'd9;

	localparam logic [1:0] KIND_ANSWER  = 2'd0;
	localparam logic [1:0] KIND_EVENT   = 2'd1;
	localparam logic [1:0] KIND_CB      = 2'd2;
	localparam logic [1:0] KIND_NO_FIRE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FREE  = 2'd1;
	localparam logic [1:0] ST_NOT_FND  = 2'd2;
	localparam logic [1:0] ST_ZERO_KEY = 2'd3;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [7:0]  task_id;
		logic [15:0] event_bits;
		logic [15:0] callback_id;
		logic [30:0] timeout_ms;
		logic [30:0] elapsed_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  status;
		logic [7:0]  fired_task;
		logic [15:0] fired_event;
		logic [15:0] fired_callback;
		logic [31:0] value;
		logic [31:0] system_clock;
		logic        last;
	} res_t;

	// One timer entry.
	typedef struct packed {
		logic        live;
		logic        is_cb;
		logic [7:0]  task_id;
		logic [15:0] tag;
		logic [31:0] remaining;
		logic [30:0] reload;
	} entry_t;

	// Operation that the head unit applies as the entry passes by.
	typedef struct packed {
		logic        active;
		logic [3:0]  req_type;
		logic [7:0]  task_id;
		logic [15:0] tag;
		logic        is_cb;
		logic [30:0] timeout_ms;
		logic [30:0] elapsed_ms;
	} op_t;

	// Report of one entry's visit to the head unit, sent back to the controller.
	typedef struct packed {
		logic        matched;
		logic        was_free;
		logic        fired;
		logic        is_cb;
		logic [7:0]  task_id;
		logic [15:0] tag;
		logic [31:0] remaining;
	} visit_t;

endpackage
`default_nettype wire

/* sv/stt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_cell: one slot of the timer ring
// Holds one entry and passes it to the next cell each rotate cycle; the head
// unit applies the current operation to the entry leaving the last cell.
// ----------------------------------------------------------------------------
module stt_cell import stt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire entry_t prev,
	output entry_t      cur
);

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= prev;
		end
	end

	assign cur = ent_q;

endmodule
`default_nettype wire

/* sv/stt_head.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_head: operation unit at the head of the ring
// Looks at the entry leaving the last cell and produces the entry that goes
// into the first cell, together with a report of what it saw.
// ----------------------------------------------------------------------------
module stt_head import stt_pkg::*; (
	input  wire op_t    op,
	input  wire logic   take_free,
	input  wire logic   kill_match,
	input  wire entry_t ent_in,
	output entry_t      ent_out,
	output visit_t      visit
);

	logic match;
	logic fire;
	logic start;

	always_comb begin
		match = ent_in.live && (ent_in.is_cb == op.is_cb) && (ent_in.tag == op.tag)
			&& (op.is_cb || ent_in.task_id == op.task_id);
		fire  = ent_in.live && ({1'b0, op.elapsed_ms} >= ent_in.remaining);
		start = op.req_type == REQ_START_EV || op.req_type == REQ_START_RL_EV
			|| op.req_type == REQ_START_CB || op.req_type == REQ_START_RL_CB;
		ent_out = ent_in;
		visit = '0;
		visit.matched   = match;
		visit.was_free  = !ent_in.live;
		visit.is_cb     = ent_in.is_cb;
		visit.task_id   = ent_in.task_id;
		visit.tag       = ent_in.tag;
		visit.remaining = ent_in.remaining;
		if (op.active) begin
			if (op.req_type == REQ_TICK) begin
				visit.fired = fire;
				if (ent_in.live) begin
					if (!fire) begin
						ent_out.remaining = ent_in.remaining - {1'b0, op.elapsed_ms};
					end else if (ent_in.reload != '0) begin
						ent_out.remaining = {1'b0, ent_in.reload};
					end else begin
						ent_out = '0;
					end
				end
			end else if (start && kill_match) begin
				// Second pass: the matched entry or the chosen free slot.
				ent_out.remaining = {1'b0, op.timeout_ms};
				if (take_free) begin
					ent_out.live    = 1'b1;
					ent_out.is_cb   = op.is_cb;
					ent_out.task_id = op.is_cb ? 8'd0 : op.task_id;
					ent_out.tag     = op.tag;
					ent_out.reload  = '0;
				end
				if (op.req_type == REQ_START_RL_EV || op.req_type == REQ_START_RL_CB) begin
					ent_out.reload = op.timeout_ms;
				end
			end else if (kill_match) begin
				ent_out = '0;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/software_timer_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_top: table of millisecond software timers
// Request decode, ring of timer cells and result delivery.
// ----------------------------------------------------------------------------
// The timers live in a ring of TIMER_SLOTS cells that rotates one slot per
// cycle, unless a result waits on output stall, past a single operation unit,
// so the slots are visited in index order. A zero key or an unknown request
// type is answered without a scan; every other request takes a full rotation
// to scan the table. Start requests that found their timer or a free slot, and
// stop requests that found their timer, take a second rotation to apply the
// change at the slot found in the first. Tick expiries are sent one item per
// fired timer, at most RMAX per tick, while the ring waits on output stall,
// and a result item that is not yet taken holds off the next request. One item
// is in work at a time.
// ----------------------------------------------------------------------------
module software_timer_table_top import stt_pkg::*; #(
	parameter int TIMER_SLOTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire req_t        in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output res_t             out_data,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int RMAX = 32;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT, S_ANS} state_t;

	state_t      state_q;
	req_t        req_q;
	op_t         op;
	logic [31:0] max_q;
	logic [31:0] clock_q;
	logic [IW-1:0] pos_q;
	logic        found_q;
	logic [IW-1:0] hit_q;
	logic        free_q;
	logic [IW-1:0] free_idx_q;
	logic [CW-1:0] count_q;
	logic [31:0] min_q;
	logic [31:0] rem_q;
	logic [5:0]  nres_q;
	res_t        hold_q;
	logic        held_q;
	res_t        hold_next;
	logic        hold_load;
	logic        take_fire;
	logic        send_out;
	logic        early_ans;
	logic        zero_key;
	logic        is_cb_req;
	logic        start_req;
	logic        shift;
	logic        take_free;
	logic        kill_match;

	entry_t ring [TIMER_SLOTS];
	entry_t head_out;
	visit_t visit;

	assign shift = (state_q == S_SCAN || state_q == S_APPLY) && !(out_valid && out_stall);

	genvar g;
	generate
		for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
			if (g == 0) begin : g_first
				stt_cell u_cell (.clk, .arst_n, .shift, .prev(head_out), .cur(ring[g]));
			end else begin : g_rest
				stt_cell u_cell (.clk, .arst_n, .shift, .prev(ring[g-1]), .cur(ring[g]));
			end
		end
	endgenerate

	// The head of the ring is the oldest slot: after reset slot i sits at
	// cell TIMER_SLOTS-1-i, so the last cell holds slot 0.
	always_comb begin
		is_cb_req = req_q.req_type == REQ_START_CB || req_q.req_type == REQ_START_RL_CB
			|| req_q.req_type == REQ_STOP_CB;
		start_req = req_q.req_type == REQ_START_EV || req_q.req_type == REQ_START_RL_EV
			|| req_q.req_type == REQ_START_CB || req_q.req_type == REQ_START_RL_CB;
		op.active     = (state_q == S_SCAN && req_q.req_type == REQ_TICK)
			|| state_q == S_APPLY;
		op.req_type   = req_q.req_type;
		op.task_id    = req_q.task_id;
		op.tag        = is_cb_req ? req_q.callback_id : req_q.event_bits;
		op.is_cb      = is_cb_req;
		op.timeout_ms = req_q.timeout_ms;
		op.elapsed_ms = req_q.elapsed_ms;
		take_free  = !found_q;
		kill_match = state_q == S_APPLY && pos_q == (found_q ? hit_q : free_idx_q);
	end

	stt_head u_head (
		.op,
		.take_free,
		.kill_match,
		.ent_in (ring[TIMER_SLOTS-1]),
		.ent_out(head_out),
		.visit
	);

	always_comb begin
		zero_key = 1'b0;
		unique case (in_data.req_type) inside
			REQ_START_EV, REQ_START_RL_EV, REQ_STOP_EV, REQ_READ:
				zero_key = in_data.event_bits == '0;
			REQ_START_CB, REQ_START_RL_CB, REQ_STOP_CB:
				zero_key = in_data.callback_id == '0;
			default: zero_key = 1'b0;
		endcase
		early_ans = zero_key || in_data.req_type > REQ_NEXT;
	end

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);

	// The newest expiry item waits in hold_q until the next one shows up or the
	// scan ends, so the final item of a tick can carry the last mark.
	always_comb begin
		take_fire = state_q == S_SCAN && shift && visit.fired && nres_q < 6'(RMAX);
		send_out  = (take_fire && held_q) || (state_q == S_ANS && !(out_valid && out_stall));
		hold_load = 1'b0;
		hold_next = '0;
		hold_next.system_clock = clock_q;
		hold_next.last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				hold_load = in_valid && !in_stall && early_ans;
				hold_next.status = zero_key ? ST_ZERO_KEY : ST_OK;
			end
			S_SCAN: begin
				hold_load = take_fire;
				hold_next.last = 1'b0;
				hold_next.result_kind = visit.is_cb ? KIND_CB : KIND_EVENT;
				hold_next.fired_task  = visit.is_cb ? 8'd0 : visit.task_id;
				hold_next.fired_event = visit.is_cb ? 16'd0 : visit.tag;
				hold_next.fired_callback = visit.is_cb ? visit.tag : 16'd0;
			end
			S_EMIT: begin
				hold_load = 1'b1;
				case (req_q.req_type) inside
					REQ_TICK: begin
						if (held_q) begin
							hold_next = hold_q;
							hold_next.last = 1'b1;
						end else begin
							hold_next.result_kind = KIND_NO_FIRE;
						end
					end
					REQ_COUNT: hold_next.value = 32'(count_q);
					REQ_NEXT:  hold_next.value = min_q;
					REQ_READ: begin
						hold_next.status = found_q ? ST_OK : ST_NOT_FND;
						hold_next.value  = found_q ? rem_q : 32'd0;
					end
					REQ_STOP_EV: hold_next.status = found_q ? ST_OK : ST_NOT_FND;
					default: begin
						if (start_req && !found_q && !free_q) hold_next.status = ST_NO_FREE;
					end
				endcase
			end
			default: hold_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 32'h7FFF_FFFF;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			clock_q   <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			nres_q    <= '0;
			held_q    <= 1'b0;
			hold_q    <= '0;
			count_q   <= '0;
			hit_q     <= '0;
			free_idx_q <= '0;
			min_q     <= '0;
			rem_q     <= '0;
			req_q     <= '0;
			out_data  <= '0;
		end else begin
			if (send_out) begin
				out_valid <= 1'b1;
				out_data  <= hold_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (hold_load) begin
				hold_q <= hold_next;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q     <= in_data;
						pos_q     <= '0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						count_q   <= '0;
						min_q     <= max_q;
						nres_q    <= '0;
						held_q    <= 1'b0;
						rem_q     <= '0;
						if (in_data.req_type == REQ_TICK) begin
							clock_q <= clock_q + {1'b0, in_data.elapsed_ms};
						end
						state_q <= early_ans ? S_ANS : S_SCAN;
					end
				end
				S_SCAN: begin
					if (shift) begin
						if (visit.matched && !found_q) begin
							found_q <= 1'b1;
							hit_q   <= pos_q;
							rem_q   <= visit.remaining;
						end
						if (visit.was_free && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= pos_q;
						end
						if (!visit.was_free) begin
							count_q <= count_q + CW'(1);
							if (visit.remaining < min_q) min_q <= visit.remaining;
						end
						if (take_fire) begin
							nres_q <= nres_q + 6'd1;
							held_q <= 1'b1;
						end
						if (pos_q == IW'(TIMER_SLOTS - 1)) begin
							pos_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							pos_q <= pos_q + IW'(1);
						end
					end
				end
				S_APPLY: begin
					if (shift) begin
						if (pos_q == IW'(TIMER_SLOTS - 1)) begin
							pos_q   <= '0;
							state_q <= S_ANS;
						end else begin
							pos_q <= pos_q + IW'(1);
						end
					end
				end
				S_EMIT: begin
					// Finish the scan: a change goes round once more, else answer.
					case (req_q.req_type) inside
						REQ_STOP_EV, REQ_STOP_CB: state_q <= found_q ? S_APPLY : S_ANS;
						default: begin
							if (start_req && (found_q || free_q)) state_q <= S_APPLY;
							else state_q <= S_ANS;
						end
					endcase
				end
				S_ANS: begin
					if (!(out_valid && out_stall)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> found_q || free_q)
		else $error("apply pass without a target slot");

endmodule
`default_nettype wire
